// ----- hdl/bsd_pkg.sv -----
// bsd_pkg: shared types, constants and the character table of the base64 stream decoder
// used by bsd_front, bsd_fifo, bsd_back and base64_stream_decoder; no dependencies
package bsd_pkg;

    localparam int MAX_STRING_CHARS = 65536;

    localparam logic [14:0] QUAD_LIMIT =
        15'((MAX_STRING_CHARS / 4 > 32767) ? 32767 : MAX_STRING_CHARS / 4);
    localparam logic [16:0] PAD_LIMIT =
        17'((MAX_STRING_CHARS > 131071) ? 131071 : MAX_STRING_CHARS);

    localparam logic [7:0] CHAR_PAD = 8'h3d;

    localparam logic [1:0] STATUS_BYTE     = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [1:0]  nres;
        logic [1:0]  status;
        logic        done;
        logic [15:0] total;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // bit 6 set marks an invalid character
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h80;
            if (c >= 8'h41 && c <= 8'h5a)
            begin
                d = c - 8'h41;
            end
            else if (c >= 8'h61 && c <= 8'h7a)
            begin
                d = c - 8'h61 + 8'd26;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30 + 8'd52;
            end
            else if (c == 8'h2b)
            begin
                d = 8'd62;
            end
            else if (c == 8'h2f)
            begin
                d = 8'd63;
            end
            else if (c == CHAR_PAD)
            begin
                d = 8'd0;
            end
            return {d[7], d[5:0]};
        end
    endfunction

endpackage

// ----- hdl/bsd_front.sv -----
// bsd_front: accepts characters, tracks quad and string state, builds result commands
// depends on bsd_pkg
module bsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_code,
    input  logic          string_end,
    input  logic          fifo_full,
    output logic          push,
    output bsd_pkg::cmd_t push_data
);
    import bsd_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [16:0] pad_reg, pad_next;
    logic [14:0] quad_reg, quad_next;
    logic        skip_reg, skip_next;
    logic [5:0]  st_reg [3];

    logic        acc;
    logic [6:0]  lookup;
    logic        bad;
    logic [5:0]  s;
    logic        is_pad;
    logic        close;
    logic [16:0] pad_inc;
    logic [14:0] quad_inc;
    logic [16:0] full_len;
    logic [16:0] total17;
    logic [15:0] total16;
    logic [1:0]  nbytes;
    logic        st_we;

    assign in_ready = !fifo_full;
    assign acc      = in_valid && in_ready;
    assign lookup   = sextet_of(char_code);
    assign bad      = lookup[6];
    assign s        = lookup[5:0];
    assign is_pad   = (char_code == CHAR_PAD);
    assign close    = (pos_reg == 2'd3);
    assign pad_inc  = (is_pad && pad_reg < PAD_LIMIT) ? pad_reg + 17'd1 : pad_reg;
    assign quad_inc = (quad_reg < QUAD_LIMIT) ? quad_reg + 15'd1 : quad_reg;
    assign full_len = {1'b0, quad_inc, 1'b0} + {2'b00, quad_inc};
    assign total17  = (full_len > pad_inc) ? full_len - pad_inc : 17'd0;
    assign total16  = total17[16] ? 16'hffff : total17[15:0];
    assign nbytes   = (pad_inc == 17'd0) ? 2'd3 : ((pad_inc == 17'd1) ? 2'd2 : 2'd1);

    always_comb
    begin
        pos_next  = pos_reg;
        pad_next  = pad_reg;
        quad_next = quad_reg;
        skip_next = skip_reg;
        st_we     = 1'b0;
        push      = 1'b0;
        push_data = '0;
        if (acc)
        begin
            if (skip_reg)
            begin
                if (string_end)
                begin
                    skip_next = 1'b0;
                    pos_next  = 2'd0;
                    pad_next  = '0;
                    quad_next = '0;
                end
            end
            else if (bad)
            begin
                push             = 1'b1;
                push_data.nres   = 2'd1;
                push_data.status = STATUS_BAD_CHAR;
                push_data.done   = 1'b1;
                pos_next         = 2'd0;
                pad_next         = '0;
                quad_next        = '0;
                skip_next        = !string_end;
            end
            else if (!close)
            begin
                st_we    = 1'b1;
                pos_next = pos_reg + 2'd1;
                pad_next = pad_inc;
                if (string_end)
                begin
                    push             = 1'b1;
                    push_data.nres   = 2'd1;
                    push_data.status = STATUS_BAD_LEN;
                    push_data.done   = 1'b1;
                    pos_next         = 2'd0;
                    pad_next         = '0;
                    quad_next        = '0;
                end
            end
            else
            begin
                push             = 1'b1;
                push_data.byte0  = {st_reg[0], st_reg[1][5:4]};
                push_data.byte1  = {st_reg[1][3:0], st_reg[2][5:2]};
                push_data.byte2  = {st_reg[2][1:0], s};
                push_data.nres   = nbytes;
                push_data.status = STATUS_BYTE;
                push_data.done   = string_end;
                push_data.total  = string_end ? total16 : 16'd0;
                pos_next         = 2'd0;
                pad_next         = string_end ? 17'd0 : pad_inc;
                quad_next        = string_end ? 15'd0 : quad_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            pad_reg  <= '0;
            quad_reg <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            quad_reg <= quad_next;
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_reg[pos_reg] <= s;
        end
    end

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (pos_reg == 2'd0 && pad_reg == 17'd0 && quad_reg == 15'd0))
        else $error("string state not cleared while skipping");

    a_push_nres: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.nres != 2'd0))
        else $error("command with no results");

endmodule

// ----- hdl/bsd_fifo.sv -----
// bsd_fifo: short command queue between front and back
// depends on bsd_pkg
module bsd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bsd_pkg::cmd_t       push_data,
    input  logic                pop,
    output bsd_pkg::cmd_t       head,
    output bsd_pkg::fifo_stat_t stat
);
    import bsd_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count past depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

endmodule

// ----- hdl/bsd_back.sv -----
// bsd_back: expands queued commands into result transactions, one per cycle while out_ready is high
// depends on bsd_pkg
module bsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bsd_pkg::cmd_t       head,
    input  bsd_pkg::fifo_stat_t stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          data_byte,
    output logic [1:0]          status,
    output logic                run_last,
    output logic                string_done,
    output logic [15:0]         total_length
);
    import bsd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last_res;
    logic       acc;

    assign out_valid    = !stat.empty;
    assign last_res     = ((idx_reg + 2'd1) == head.nres);
    assign acc          = out_valid && out_ready;
    assign pop          = acc && last_res;
    assign status       = head.status;
    assign run_last     = last_res;
    assign string_done  = head.done && last_res;
    assign total_length = string_done ? head.total : 16'd0;

    always_comb
    begin
        case (idx_reg)
            2'd0:    data_byte = head.byte0;
            2'd1:    data_byte = head.byte1;
            2'd2:    data_byte = head.byte2;
            default: data_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (acc)
        begin
            idx_next = last_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg < head.nres))
        else $error("result index past command size");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> (idx_reg == 2'd0))
        else $error("result index left over with empty queue");

endmodule

// ----- hdl/base64_stream_decoder.sv -----
// base64_stream_decoder: streaming base64 decoder, one character per transaction
// results: the command that a taken character causes is registered into the queue and offered from its head
// throughput: one character per cycle while the queue is not full; results leave at one per cycle
// while out_ready is high, and the bytes of a quad that yields three are absorbed by a four-entry queue
// reset: rst_n asynchronous, clears quad, pad, quad-count, skip and queue state;
// the sextet store is not reset
module base64_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        string_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [1:0]  status,
    output logic        run_last,
    output logic        string_done,
    output logic [15:0] total_length
);
    import bsd_pkg::*;

    logic       push;
    logic       pop;
    cmd_t       push_data;
    cmd_t       head;
    fifo_stat_t stat;

    bsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .string_end (string_end),
        .fifo_full  (stat.full),
        .push       (push),
        .push_data  (push_data)
    );

    bsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    bsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .stat         (stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .status       (status),
        .run_last     (run_last),
        .string_done  (string_done),
        .total_length (total_length)
    );

endmodule

// ----- tb/base64_stream_decoder_tb.sv -----
// base64_stream_decoder_tb: self-checking testbench for the streaming base64 decoder
// drives characters and compares every decoded result with an in-bench prediction
// depends on bsd_pkg and base64_stream_decoder
`timescale 1ns / 1ps

module base64_stream_decoder_tb;

    import bsd_pkg::*;

    localparam int QUADS_MAX = (MAX_STRING_CHARS / 4 > 32767) ? 32767 : MAX_STRING_CHARS / 4;
    localparam int PADS_MAX  = (MAX_STRING_CHARS > 131071) ? 131071 : MAX_STRING_CHARS;

    typedef struct packed {
        logic [7:0] code;
        logic       is_end;
    } char_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic        run_last;
        logic        string_done;
        logic [15:0] total_length;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'h00;
    logic        string_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        run_last;
    logic        string_done;
    logic [15:0] total_length;

    char_item_t pending_chars [$];
    decoded_t   predicted_out [$];
    int         sextet_lut [256];
    int         chars_total = 0;
    int         chars_taken = 0;
    int         mismatches = 0;

    // decoder state as predicted
    logic [1:0]  quad_pos = 2'd0;
    logic [5:0]  sextets [3] = '{6'd0, 6'd0, 6'd0};
    logic [16:0] pad_cnt = 17'd0;
    logic [14:0] quad_cnt = 15'd0;
    logic        skipping = 1'b0;

    int         gap_left = 0;
    int         calm_in = 0;
    int         stall_left = 0;
    int         calm_out = 0;
    char_item_t next_char;
    decoded_t   want;

    base64_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .string_end   (string_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .status       (status),
        .run_last     (run_last),
        .string_done  (string_done),
        .total_length (total_length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] b64_char(input int v);
        if (v < 26)
        begin
            return 8'(8'h41 + v);
        end
        if (v < 52)
        begin
            return 8'(8'h61 + v - 26);
        end
        if (v < 62)
        begin
            return 8'(8'h30 + v - 52);
        end
        return (v == 62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic logic [7:0] random_invalid();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (sextet_lut[c] >= 0)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic pick_gap(inout int calm, output int gap);
        int r;
        gap = 0;
        if (calm > 0)
        begin
            calm--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                calm = $urandom_range(30, 120);
            end
            else if (r >= 55 && r < 88)
            begin
                gap = $urandom_range(1, 3);
            end
            else if (r >= 88 && r < 97)
            begin
                gap = $urandom_range(4, 8);
            end
            else if (r >= 97)
            begin
                gap = $urandom_range(15, 40);
            end
        end
    endtask

    task automatic clear_string();
        quad_pos = 2'd0;
        pad_cnt  = 17'd0;
        quad_cnt = 15'd0;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic is_end);
        decoded_t res [3];
        int       n;
        int       sx;
        int       full;
        int       total;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end
        if (skipping)
        begin
            if (is_end)
            begin
                skipping = 1'b0;
                clear_string();
            end
            return;
        end
        sx = sextet_lut[c];
        if (sx < 0)
        begin
            res[0].status      = STATUS_BAD_CHAR;
            res[0].run_last    = 1'b1;
            res[0].string_done = 1'b1;
            predicted_out.push_back(res[0]);
            clear_string();
            skipping = !is_end;
            return;
        end
        if (c == CHAR_PAD && pad_cnt < PADS_MAX)
        begin
            pad_cnt++;
        end
        if (quad_pos < 2'd3)
        begin
            sextets[quad_pos] = 6'(sx);
            quad_pos++;
        end
        else
        begin
            res[n].data_byte = {sextets[0], sextets[1][5:4]};
            n = n + 1;
            if (pad_cnt <= 17'd1)
            begin
                res[n].data_byte = {sextets[1][3:0], sextets[2][5:2]};
                n = n + 1;
            end
            if (pad_cnt == 17'd0)
            begin
                res[n].data_byte = {sextets[2][1:0], 6'(sx)};
                n = n + 1;
            end
            quad_pos = 2'd0;
            if (quad_cnt < QUADS_MAX)
            begin
                quad_cnt++;
            end
        end
        if (is_end)
        begin
            if (quad_pos != 2'd0)
            begin
                n = 1;
                res[0] = '0;
                res[0].status      = STATUS_BAD_LEN;
                res[0].string_done = 1'b1;
            end
            else
            begin
                full  = int'(quad_cnt) * 3;
                total = (full > int'(pad_cnt)) ? full - int'(pad_cnt) : 0;
                if (total > 65535)
                begin
                    total = 65535;
                end
                res[n - 1].string_done  = 1'b1;
                res[n - 1].total_length = 16'(total);
            end
            clear_string();
        end
        if (n > 0)
        begin
            res[n - 1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            predicted_out.push_back(res[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, exp_val);
    endtask

    task automatic push_char(input logic [7:0] c, input logic is_end);
        char_item_t item;
        item.code   = c;
        item.is_end = is_end;
        pending_chars.push_back(item);
    endtask

    task automatic push_text(input string s, input logic is_end);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], is_end && (i == s.len() - 1));
        end
    endtask

    task automatic add_random_string(inout int counted);
        logic [7:0] text [$];
        int         kind;
        int         len;
        int         pads;
        bit         dead;
        kind = $urandom_range(0, 99);
        dead = 1'b0;
        if (kind < 75)
        begin
            len = 4 * $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                text.push_back(b64_char($urandom_range(0, 63)));
            end
            pads = $urandom_range(0, 2);
            for (int i = 0; i < pads; i++)
            begin
                text[len - 1 - i] = CHAR_PAD;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                text[$urandom_range(0, len - 1)] = CHAR_PAD;
            end
        end
        else if (kind < 88)
        begin
            len = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                text.push_back(b64_char($urandom_range(0, 63)));
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if (kind < 94)
                begin
                    text.push_back(b64_char($urandom_range(0, 63)));
                end
                else
                begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            end
            text[$urandom_range(0, len - 1)] = random_invalid();
        end
        for (int i = 0; i < len; i++)
        begin
            push_char(text[i], i == len - 1);
            if (!dead)
            begin
                counted++;
            end
            if (sextet_lut[text[i]] < 0)
            begin
                dead = 1'b1;
            end
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int counted;
        counted = 0;
        for (int c = 0; c < 256; c++)
        begin
            sextet_lut[c] = -1;
        end
        for (int v = 0; v < 64; v++)
        begin
            sextet_lut[b64_char(v)] = v;
        end
        sextet_lut[CHAR_PAD] = 0;

        push_text("TWFu", 1'b1);
        push_text("+/09a=z=", 1'b1);
        push_text("AB", 1'b0);
        push_char(8'h80, 1'b0);
        push_text("CD", 1'b0);
        push_text("E", 1'b1);
        push_char(8'hff, 1'b1);
        push_char(8'h00, 1'b0);
        push_text("x", 1'b1);
        push_text("ABC", 1'b1);

        while (counted < 356)
        begin
            add_random_string(counted);
        end

        chars_total = pending_chars.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_taken < chars_total || predicted_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && predicted_out.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #200000000;
        $display("TEST FAILED");
        $finish;
    end

    // character driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                decode_char(char_code, string_end);
                chars_taken++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                next_char = pending_chars.pop_front();
                char_code  <= next_char.code;
                string_end <= next_char.is_end;
                in_valid   <= 1'b1;
                pick_gap(calm_in, gap_left);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_out.size() == 0)
                begin
                    report_mismatch("unpredicted transaction, data_byte", data_byte, -1);
                end
                else
                begin
                    want = predicted_out.pop_front();
                    if (data_byte !== want.data_byte)
                    begin
                        report_mismatch("data_byte", data_byte, want.data_byte);
                    end
                    if (status !== want.status)
                    begin
                        report_mismatch("status", status, want.status);
                    end
                    if (run_last !== want.run_last)
                    begin
                        report_mismatch("run_last", run_last, want.run_last);
                    end
                    if (string_done !== want.string_done)
                    begin
                        report_mismatch("string_done", string_done, want.string_done);
                    end
                    if (total_length !== want.total_length)
                    begin
                        report_mismatch("total_length", total_length, want.total_length);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                pick_gap(calm_out, stall_left);
            end
        end
    end

endmodule
